// ----- src/fcc_pkg.sv -----
// Shared types and constants for the FAT cluster chain engine.
package fcc_pkg;

   localparam int CMD_W      = 3;
   localparam int CLUSTER_W  = 12;
   localparam int LINK_W     = 28;
   localparam int STATUS_W   = 2;
   localparam int ADDR_W     = CLUSTER_W + 1;
   localparam int CLUSTER_SPAN = 1 << CLUSTER_W;

   localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOCONF = 2'd2;

   localparam logic [LINK_W-1:0] LINK_MASK  = 28'hFFF_FFFF;
   localparam logic [LINK_W-1:0] END_MARK   = 28'hFFF_FFF8;
   localparam logic [LINK_W-1:0] DATA_START = 28'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RD_DATA,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DONE
   } fcc_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CLUSTER_W-1:0] total;
      logic [LINK_W-1:0]    value;
   } fcc_result_type;

endpackage

// ----- src/fcc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module fcc_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fcc_ctrl.sv -----
// Command sequencer with shared table scan/walk datapath and link table RAM.
module fcc_ctrl #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fcc_pkg::CLUSTER_W-1:0]   highest_cluster,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fcc_pkg::CMD_W-1:0]       req_command,
   input  logic [fcc_pkg::CLUSTER_W-1:0]   req_cluster,
   input  logic [fcc_pkg::LINK_W-1:0]      req_link,
   input  logic                            out_free,
   output logic                            done,
   output fcc_pkg::fcc_result_type         result
);

   localparam int USED_ENTRIES = (TABLE_ENTRIES < fcc_pkg::CLUSTER_SPAN) ?
                                 TABLE_ENTRIES : fcc_pkg::CLUSTER_SPAN;
   localparam int AW = $clog2(USED_ENTRIES);
   localparam logic [fcc_pkg::ADDR_W-1:0] USED_LIMIT = fcc_pkg::ADDR_W'(USED_ENTRIES);
   localparam logic [AW-1:0] CLR_LAST = AW'(USED_ENTRIES - 1);

   fcc_pkg::fcc_state_type state_ff, state_in;

   logic [AW-1:0]                   clr_ff, clr_in;
   logic [fcc_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [fcc_pkg::CLUSTER_W-1:0]   cl_ff, cl_in;
   logic [fcc_pkg::LINK_W-1:0]      lv_ff, lv_in;
   logic [fcc_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [AW-1:0]                   pend_addr_ff, pend_addr_in;
   logic [fcc_pkg::CLUSTER_W-1:0]   cnt_ff, cnt_in;
   fcc_pkg::fcc_result_type         res_ff, res_in;

   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [fcc_pkg::LINK_W-1:0]      ram_wr_data;
   logic                            ram_rd_en;
   logic [AW-1:0]                   ram_rd_addr;
   logic [fcc_pkg::LINK_W-1:0]      ram_rd_data;

   logic [fcc_pkg::ADDR_W-1:0]      hc_ext;
   logic                            addr_in_tbl;
   logic                            cl_in_tbl;
   logic                            cl_in_range;
   logic                            issue_ok;
   logic                            pend_free;
   logic                            is_alloc;
   logic [fcc_pkg::LINK_W-1:0]      walk_word;
   logic                            walk_more;

   fcc_ram #(
      .WIDTH (fcc_pkg::LINK_W),
      .DEPTH (USED_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign hc_ext      = {1'b0, highest_cluster};
   assign addr_in_tbl = addr_ff < USED_LIMIT;
   assign cl_in_tbl   = {1'b0, cl_ff} < USED_LIMIT;
   assign cl_in_range = (cl_ff >= fcc_pkg::CLUSTER_W'(2)) && (cl_ff <= highest_cluster);
   assign issue_ok    = (addr_ff <= hc_ext) && addr_in_tbl;
   assign pend_free   = pend_valid_ff && (ram_rd_data == '0);
   assign is_alloc    = cmd_ff == fcc_pkg::CMD_ALLOC;
   assign walk_word   = addr_in_tbl ? ram_rd_data : fcc_pkg::LINK_MASK;
   assign walk_more   = (walk_word >= fcc_pkg::DATA_START) &&
                        (walk_word <= fcc_pkg::LINK_W'(highest_cluster));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcc_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = fcc_pkg::ST_IDLE;
         end
         fcc_pkg::ST_IDLE: begin
            if (req_valid) state_in = fcc_pkg::ST_DECODE;
         end
         fcc_pkg::ST_DECODE: begin
            case (cmd_ff)
               fcc_pkg::CMD_READ:
                  state_in = cl_in_tbl ? fcc_pkg::ST_RD_DATA : fcc_pkg::ST_DONE;
               fcc_pkg::CMD_ALLOC:
                  state_in = fcc_pkg::ST_SCAN;
               fcc_pkg::CMD_FREE:
                  state_in = cl_in_range ? fcc_pkg::ST_FREE_RD : fcc_pkg::ST_DONE;
               fcc_pkg::CMD_COUNT:
                  state_in = (highest_cluster == '0) ? fcc_pkg::ST_DONE : fcc_pkg::ST_SCAN;
               default:
                  state_in = fcc_pkg::ST_DONE;
            endcase
         end
         fcc_pkg::ST_RD_DATA: begin
            state_in = fcc_pkg::ST_DONE;
         end
         fcc_pkg::ST_SCAN: begin
            if ((is_alloc && pend_free) || !issue_ok) state_in = fcc_pkg::ST_DONE;
         end
         fcc_pkg::ST_FREE_RD: begin
            state_in = fcc_pkg::ST_FREE_CHK;
         end
         fcc_pkg::ST_FREE_CHK: begin
            state_in = walk_more ? fcc_pkg::ST_FREE_RD : fcc_pkg::ST_DONE;
         end
         fcc_pkg::ST_DONE: begin
            if (out_free) state_in = fcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = fcc_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake and table port controls
   always_comb begin
      req_ready   = state_ff == fcc_pkg::ST_IDLE;
      done        = (state_ff == fcc_pkg::ST_DONE) && out_free;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff[AW-1:0];
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = addr_ff[AW-1:0];
      case (state_ff)
         fcc_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
         end
         fcc_pkg::ST_DECODE: begin
            ram_rd_addr = cl_ff[AW-1:0];
            ram_wr_addr = cl_ff[AW-1:0];
            ram_wr_data = lv_ff;
            ram_rd_en   = (cmd_ff == fcc_pkg::CMD_READ) && cl_in_tbl;
            ram_wr_en   = (cmd_ff == fcc_pkg::CMD_WRITE) && cl_in_tbl;
         end
         fcc_pkg::ST_SCAN: begin
            ram_rd_en   = issue_ok;
            ram_wr_en   = is_alloc && pend_free;
            ram_wr_addr = pend_addr_ff;
            ram_wr_data = fcc_pkg::END_MARK;
         end
         fcc_pkg::ST_FREE_RD: begin
            ram_rd_en = addr_in_tbl;
         end
         fcc_pkg::ST_FREE_CHK: begin
            ram_wr_en = addr_in_tbl;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      cl_in         = cl_ff;
      lv_in         = lv_ff;
      addr_in       = addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      case (state_ff)
         fcc_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         fcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               cl_in  = req_cluster;
               lv_in  = req_link;
            end
         end
         fcc_pkg::ST_DECODE: begin
            res_in        = '0;
            pend_valid_in = 1'b0;
            cnt_in        = '0;
            addr_in       = {1'b0, cl_ff};
            case (cmd_ff)
               fcc_pkg::CMD_READ: begin
                  if (!cl_in_tbl) res_in.value = fcc_pkg::LINK_MASK;
               end
               fcc_pkg::CMD_ALLOC: begin
                  addr_in = fcc_pkg::ADDR_W'(2);
               end
               fcc_pkg::CMD_COUNT: begin
                  addr_in = fcc_pkg::ADDR_W'(2);
                  if (highest_cluster == '0) begin
                     res_in.status = fcc_pkg::STAT_NOCONF;
                  end else begin
                     res_in.total = highest_cluster - fcc_pkg::CLUSTER_W'(1);
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         fcc_pkg::ST_RD_DATA: begin
            res_in.value = ram_rd_data;
         end
         fcc_pkg::ST_SCAN: begin
            addr_in       = addr_ff + fcc_pkg::ADDR_W'(1);
            pend_valid_in = issue_ok;
            pend_addr_in  = addr_ff[AW-1:0];
            cnt_in        = cnt_ff + fcc_pkg::CLUSTER_W'(pend_free);
            if (is_alloc) begin
               if (pend_free) begin
                  res_in.value = fcc_pkg::LINK_W'(pend_addr_ff);
               end else if (!issue_ok) begin
                  res_in.status = fcc_pkg::STAT_FULL;
               end
            end else if (!issue_ok) begin
               res_in.value = fcc_pkg::LINK_W'(cnt_in);
            end
         end
         fcc_pkg::ST_FREE_CHK: begin
            addr_in = {1'b0, walk_word[fcc_pkg::CLUSTER_W-1:0]};
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fcc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cl_ff        <= cl_in;
      lv_ff        <= lv_in;
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
   end

   assign result = res_ff;

`ifndef SYNTHESIS
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcc_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during table clear");

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == fcc_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after result");

   a_scan_write_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcc_pkg::ST_SCAN && ram_wr_en) |->
      (is_alloc && ram_wr_data == fcc_pkg::END_MARK && state_in == fcc_pkg::ST_DONE))
      else $error("scan wrote table outside allocate");

   a_walk_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcc_pkg::ST_FREE_CHK && ram_wr_en) |-> (ram_wr_data == '0))
      else $error("free walk wrote nonzero link");
`endif

endmodule

// ----- src/fat_cluster_chain_engine.sv -----
// Top level: FAT32 cluster allocation table engine with config and result register.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | command, cluster, link_value
//   rsp     | out | rsp_tvalid/rsp_tready  | result_value, usable_count, status
//   csr     | in  | csr_valid/csr_ready    | highest_cluster
//
// Free chain walks the chain and clears each link visited. Allocate and count sweep
// the table one RAM read per cycle, from cluster 2 up to highest_cluster.
// After reset a clearing pass writes min(TABLE_ENTRIES, 4096) entries, one
// per cycle, before req_tready rises.
// One command at a time; the next is taken while a result waits in rsp.
module fat_cluster_chain_engine #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command[2:0], cluster[14:3], link_value[42:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_value[27:0], usable_count[39:28], status[41:40]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   logic [fcc_pkg::CLUSTER_W-1:0] hc_ff;
   logic                          rsp_valid_ff;
   fcc_pkg::fcc_result_type       rsp_data_ff;
   fcc_pkg::fcc_result_type       result;
   logic                          done;
   logic                          out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   fcc_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .highest_cluster (hc_ff),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_command     (req_tdata[2:0]),
      .req_cluster     (req_tdata[14:3]),
      .req_link        (req_tdata[42:15]),
      .out_free        (out_free),
      .done            (done),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) hc_ff <= csr_data;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

endmodule
